### rtl/ngfs_pkg.sv
// ----------------------------------------------------------------------------
// ngfs_pkg
// Shared types, widths and helpers of the n-gram fitness scorer.
// ----------------------------------------------------------------------------
package ngfs_pkg;

	localparam int LETTER_BITS = 5;
	localparam int MAX_NGRAM   = 4;
	localparam int LEN_W       = 3;
	localparam int WIN_W       = LETTER_BITS * MAX_NGRAM;
	localparam int ADDR_W      = 20;
	localparam int SCORE_W     = 16;
	localparam int CODE_W      = 8;
	localparam int CHAR_DEPTH  = 1 << CODE_W;
	localparam int SCORE_DEPTH = 1 << ADDR_W;
	localparam int SUM_W       = 40;
	localparam int CNT_W       = 24;
	localparam int AVG_W       = 21;
	localparam int FRAC_W      = 8;
	localparam int DIVISOR_W   = CNT_W + 4;
	localparam int DIVIDEND_W  = SUM_W + FRAC_W;
	localparam int STEP_W      = $clog2(DIVIDEND_W);

	typedef enum logic [1:0] {
		CMD_MAP    = 2'd0,
		CMD_SCORE  = 2'd1,
		CMD_CHAR   = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = len;
		if (len == '0) begin
			r = LEN_W'(1);
		end else if (len > LEN_W'(MAX_NGRAM)) begin
			r = LEN_W'(MAX_NGRAM);
		end
		return r;
	endfunction

	function automatic logic [WIN_W-1:0] win_mask(input logic [LEN_W-1:0] len);
		logic [WIN_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_NGRAM; i++) begin
			if (LEN_W'(i) < len) begin
				m[i*LETTER_BITS +: LETTER_BITS] = '1;
			end
		end
		return m;
	endfunction

endpackage

### rtl/ngfs_ram.sv
// ----------------------------------------------------------------------------
// ngfs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ngfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/ngfs_div.sv
// ----------------------------------------------------------------------------
// ngfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ngfs_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ngfs_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [ngfs_pkg::DIVISOR_W-1:0]   divisor,
	output logic                             done,
	output logic [ngfs_pkg::DIVIDEND_W-1:0]  quotient
);
	import ngfs_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff      = rem_shift - {1'b0, div_q};
	assign fits      = rem_shift >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(DIVIDEND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/ngram_fitness_scorer_top.sv
// ----------------------------------------------------------------------------
// ngram_fitness_scorer_top
// N-gram fitness scorer: character map, score table, saturating sum and
// count, and a tenth of the mean per n-gram in unsigned Q.8 at finish.
//
// A text character passes through the character map read and, when it
// completes an n-gram, the score table read and the add. A finish on
// scored n-grams passes through accept, setup, 48 steps of the restoring
// divider, its done flag and the output load; empty text skips the
// divider. in_stall is high while a text character or a finish is in
// progress after its accept; map and table writes never raise it. A
// finished result sits in an output register, so further transactions
// proceed while it waits; a second finish holds only if the first result
// has not been taken.
// ----------------------------------------------------------------------------
module ngram_fitness_scorer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ngfs_pkg::LEN_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [ngfs_pkg::CODE_W-1:0]    char_code,
	input  logic                           map_valid,
	input  logic [ngfs_pkg::LETTER_BITS-1:0] map_index,
	input  logic [ngfs_pkg::ADDR_W-1:0]    table_address,
	input  logic [ngfs_pkg::SCORE_W-1:0]   score_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ngfs_pkg::SUM_W-1:0]     total_score,
	output logic [ngfs_pkg::CNT_W-1:0]     scored_count,
	output logic [ngfs_pkg::AVG_W-1:0]     average_q8,
	output logic                           empty_text,
	output logic                           overflow
);
	import ngfs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_LETTER  = 6'b000010,
		ST_SCORE   = 6'b000100,
		ST_FINISH  = 6'b001000,
		ST_DIVWAIT = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]       ngram_length_q;
	logic [CHAR_DEPTH-1:0]  map_valid_q;
	logic                   letter_valid_q;
	logic [WIN_W-1:0]       window_q;
	logic [LEN_W-1:0]       letters_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;

	logic                   out_valid_q;
	logic [SUM_W-1:0]       total_q;
	logic [CNT_W-1:0]       count_out_q;
	logic [AVG_W-1:0]       avg_q;
	logic                   empty_q;
	logic                   ovf_out_q;

	logic                   in_accept;
	cmd_t                   cmd;
	logic                   char_we;
	logic [LETTER_BITS-1:0] char_rdata;
	logic                   score_we;
	logic [ADDR_W-1:0]      score_addr;
	logic [SCORE_W-1:0]     score_rdata;

	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       letters_next;
	logic [WIN_W-1:0]       window_next;
	logic                   scored;
	logic [SUM_W:0]         sum_ext;

	logic                   div_start;
	logic                   div_done;
	logic [DIVISOR_W-1:0]   divisor;
	logic [DIVIDEND_W-1:0]  quotient;
	logic [AVG_W-1:0]       avg_sat;
	logic                   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cmd       = cmd_t'(command);
	assign char_we   = in_accept && (cmd == CMD_MAP);
	assign score_we  = in_accept && (cmd == CMD_SCORE);

	assign len          = eff_len(ngram_length_q);
	assign letters_next = (letters_q < len) ? letters_q + LEN_W'(1) : letters_q;
	assign window_next  = {window_q[WIN_W-LETTER_BITS-1:0], char_rdata} & win_mask(len);
	assign scored       = letters_next >= len;
	assign sum_ext      = {1'b0, sum_q} + (SUM_W+1)'(score_rdata);

	assign score_addr = (state_q == ST_LETTER) ? window_next[ADDR_W-1:0] : table_address;

	assign div_start = (state_q == ST_FINISH) && (count_q != '0);
	assign divisor   = {1'b0, count_q, 3'b000} + {3'b000, count_q, 1'b0};
	assign avg_sat   = (|quotient[DIVIDEND_W-1:AVG_W]) ? '1 : quotient[AVG_W-1:0];
	assign out_free  = !out_valid_q || !out_stall;

	ngfs_ram #(
		.WIDTH (LETTER_BITS),
		.DEPTH (CHAR_DEPTH)
	) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.addr  (char_code),
		.wdata (map_index),
		.rdata (char_rdata)
	);

	ngfs_ram #(
		.WIDTH (SCORE_W),
		.DEPTH (SCORE_DEPTH)
	) u_score_ram (
		.clk   (clk),
		.we    (score_we),
		.addr  (score_addr),
		.wdata (score_value),
		.rdata (score_rdata)
	);

	ngfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q, FRAC_W'(0)}),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ngram_length_q <= LEN_W'(MAX_NGRAM);
			map_valid_q    <= '0;
			letter_valid_q <= 1'b0;
			window_q       <= '0;
			letters_q      <= '0;
			sum_q          <= '0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				ngram_length_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (cmd)
							CMD_MAP: begin
								map_valid_q[char_code] <= map_valid;
							end
							CMD_CHAR: begin
								letter_valid_q <= map_valid_q[char_code];
								state_q        <= ST_LETTER;
							end
							CMD_FINISH: begin
								state_q <= ST_FINISH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LETTER: begin
					if (letter_valid_q) begin
						window_q  <= window_next;
						letters_q <= letters_next;
						state_q   <= scored ? ST_SCORE : ST_IDLE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCORE: begin
					if (sum_ext[SUM_W] || (&count_q)) begin
						ovf_q <= 1'b1;
					end
					if (sum_ext[SUM_W]) begin
						sum_q <= '1;
					end else begin
						sum_q <= sum_ext[SUM_W-1:0];
					end
					if (!(&count_q)) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_FINISH: begin
					state_q <= (count_q == '0) ? ST_DONE : ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						window_q    <= '0;
						letters_q   <= '0;
						sum_q       <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			total_q     <= sum_q;
			count_out_q <= count_q;
			empty_q     <= (count_q == '0);
			avg_q       <= (count_q == '0) ? '0 : avg_sat;
			ovf_out_q   <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign total_score  = total_q;
	assign scored_count = count_out_q;
	assign average_q8   = avg_q;
	assign empty_text   = empty_q;
	assign overflow     = ovf_out_q;

endmodule

### bench/ngram_fitness_scorer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_fitness_scorer_checker
// Watches the configuration port and both channels of the scorer. It keeps
// its own character map, score table, window and accumulators. For every
// finish transaction it works out the expected text score, and it compares
// each delivered result with the oldest one still due.
// ----------------------------------------------------------------------------
module ngram_fitness_scorer_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ngfs_pkg::LEN_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       command,
	input  logic [ngfs_pkg::CODE_W-1:0]      char_code,
	input  logic                             map_valid,
	input  logic [ngfs_pkg::LETTER_BITS-1:0] map_index,
	input  logic [ngfs_pkg::ADDR_W-1:0]      table_address,
	input  logic [ngfs_pkg::SCORE_W-1:0]     score_value,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [ngfs_pkg::SUM_W-1:0]       total_score,
	input  logic [ngfs_pkg::CNT_W-1:0]       scored_count,
	input  logic [ngfs_pkg::AVG_W-1:0]       average_q8,
	input  logic                             empty_text,
	input  logic                             overflow,
	output int                               fail_count,
	output int                               due_count
);
	import ngfs_pkg::*;

	localparam int TEN = 10;

	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic [CNT_W-1:0] count;
		logic [AVG_W-1:0] mean;
		logic             empty;
		logic             sat;
	} text_score_t;

	text_score_t            scores_due[$];
	logic [LETTER_BITS:0]   letter_map [CHAR_DEPTH];
	logic [SCORE_W-1:0]     score_mem [logic [ADDR_W-1:0]];
	logic [LEN_W-1:0]       len_reg;
	logic [WIN_W-1:0]       window;
	logic [LEN_W-1:0]       seen;
	logic [SUM_W-1:0]       sum;
	logic [CNT_W-1:0]       count;
	logic                   saturated;
	int                     errors = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic logic [LEN_W-1:0] gram_letters(input logic [LEN_W-1:0] l);
		logic [LEN_W-1:0] n;
		n = l;
		if (l == '0) begin
			n = LEN_W'(1);
		end else if (l > LEN_W'(MAX_NGRAM)) begin
			n = LEN_W'(MAX_NGRAM);
		end
		return n;
	endfunction

	task automatic shift_letter(input logic [LETTER_BITS-1:0] letter);
		logic [LEN_W-1:0]   n;
		logic [WIN_W-1:0]   keep;
		logic [SUM_W:0]     wide;
		logic [SCORE_W-1:0] s;
		n = gram_letters(len_reg);
		keep = {WIN_W{1'b1}} >> (LETTER_BITS * (MAX_NGRAM - n));
		window = ((window << LETTER_BITS) | WIN_W'(letter)) & keep;
		if (seen < n) begin
			seen++;
		end
		if (seen >= n) begin
			s = score_mem.exists(window[ADDR_W-1:0]) ? score_mem[window[ADDR_W-1:0]] : '0;
			wide = {1'b0, sum} + (SUM_W + 1)'(s);
			if (wide[SUM_W]) begin
				sum = '1;
				saturated = 1'b1;
			end else begin
				sum = wide[SUM_W-1:0];
			end
			if (count == '1) begin
				saturated = 1'b1;
			end else begin
				count++;
			end
		end
	endtask

	function automatic text_score_t close_text();
		text_score_t             r;
		logic [DIVIDEND_W-1:0]   num;
		logic [DIVISOR_W-1:0]    den;
		logic [DIVIDEND_W-1:0]   q;
		r.total = sum;
		r.count = count;
		r.empty = (count == '0);
		r.sat = saturated;
		r.mean = '0;
		if (!r.empty) begin
			num = {sum, {FRAC_W{1'b0}}};
			den = DIVISOR_W'(count) * DIVISOR_W'(TEN);
			q = num / DIVIDEND_W'(den);
			r.mean = (|q[DIVIDEND_W-1:AVG_W]) ? '1 : q[AVG_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_score_t want;
		if (!arst_n) begin
			len_reg = LEN_W'(MAX_NGRAM);
			for (int i = 0; i < CHAR_DEPTH; i++) begin
				letter_map[i] = '0;
			end
			score_mem.delete();
			scores_due.delete();
			window = '0;
			seen = '0;
			sum = '0;
			count = '0;
			saturated = 1'b0;
			fail_count <= 0;
			due_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (scores_due.size() == 0) begin
					report($sformatf("result with no finish pending, total_score %0d",
						total_score));
				end else begin
					want = scores_due.pop_front();
					if (total_score !== want.total) begin
						report($sformatf("total_score got %0d expected %0d",
							total_score, want.total));
					end
					if (scored_count !== want.count) begin
						report($sformatf("scored_count got %0d expected %0d",
							scored_count, want.count));
					end
					if (average_q8 !== want.mean) begin
						report($sformatf("average_q8 got %0d expected %0d",
							average_q8, want.mean));
					end
					if (empty_text !== want.empty) begin
						report($sformatf("empty_text got %0b expected %0b",
							empty_text, want.empty));
					end
					if (overflow !== want.sat) begin
						report($sformatf("overflow got %0b expected %0b",
							overflow, want.sat));
					end
				end
			end
			if (cfg_we) begin
				len_reg = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				case (cmd_t'(command))
					CMD_MAP: begin
						letter_map[char_code] = {map_valid, map_index};
					end
					CMD_SCORE: begin
						score_mem[table_address] = score_value;
					end
					CMD_CHAR: begin
						if (letter_map[char_code][LETTER_BITS]) begin
							shift_letter(letter_map[char_code][LETTER_BITS-1:0]);
						end
					end
					default: begin
						scores_due = {scores_due, close_text()};
						window = '0;
						seen = '0;
						sum = '0;
						count = '0;
						saturated = 1'b0;
					end
				endcase
			end
			fail_count <= errors;
			due_count <= scores_due.size();
		end
	end

endmodule

### bench/ngram_fitness_scorer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_fitness_scorer_top_test
// Loads a character map and a score table that covers every window the text
// can form, then streams directed and random text, finish, map and table
// transactions through the scorer under several n-gram lengths, with random
// idling on both channels and one long receiver hold-off. A checker beside
// the block predicts and compares every text score.
// ----------------------------------------------------------------------------
module ngram_fitness_scorer_top_test;
	import ngfs_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 52;
	localparam logic [4*LETTER_BITS-1:0] ALPHABET = {5'd21, 5'd10, 5'd31, 5'd0};
	localparam logic [8*LEN_W-1:0] LENGTH_PLAN =
		{3'd4, 3'd6, 3'd5, 3'd3, 3'd2, 3'd7, 3'd0, 3'd1};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [LEN_W-1:0]       cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic [1:0]             command;
	logic [CODE_W-1:0]      char_code;
	logic                   map_valid;
	logic [LETTER_BITS-1:0] map_index;
	logic [ADDR_W-1:0]      table_address;
	logic [SCORE_W-1:0]     score_value;
	logic                   out_valid;
	logic                   out_stall;
	logic [SUM_W-1:0]       total_score;
	logic [CNT_W-1:0]       scored_count;
	logic [AVG_W-1:0]       average_q8;
	logic                   empty_text;
	logic                   overflow;

	int fail_count;
	int due_count;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	ngram_fitness_scorer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.char_code     (char_code),
		.map_valid     (map_valid),
		.map_index     (map_index),
		.table_address (table_address),
		.score_value   (score_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.total_score   (total_score),
		.scored_count  (scored_count),
		.average_q8    (average_q8),
		.empty_text    (empty_text),
		.overflow      (overflow)
	);

	ngram_fitness_scorer_checker scorer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.char_code     (char_code),
		.map_valid     (map_valid),
		.map_index     (map_index),
		.table_address (table_address),
		.score_value   (score_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.total_score   (total_score),
		.scored_count  (scored_count),
		.average_q8    (average_q8),
		.empty_text    (empty_text),
		.overflow      (overflow),
		.fail_count    (fail_count),
		.due_count     (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ngram_fitness_scorer_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_taken = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic logic [LETTER_BITS-1:0] pick_letter();
		return ALPHABET[$urandom_range(0, 3) * LETTER_BITS +: LETTER_BITS];
	endfunction

	// window address built from four alphabet letters selected by k
	function automatic logic [ADDR_W-1:0] gram_address(input logic [7:0] k);
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < MAX_NGRAM; i++) begin
			a[i*LETTER_BITS +: LETTER_BITS] = ALPHABET[k[2*i +: 2] * LETTER_BITS +: LETTER_BITS];
		end
		return a;
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [CODE_W-1:0] code,
		input logic mv, input logic [LETTER_BITS-1:0] mi,
		input logic [ADDR_W-1:0] addr, input logic [SCORE_W-1:0] sv);
		in_valid <= 1'b1;
		command <= cmd;
		char_code <= code;
		map_valid <= mv;
		map_index <= mi;
		table_address <= addr;
		score_value <= sv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic put_text(input logic [CODE_W-1:0] code);
		send_item(CMD_CHAR, code, 1'($urandom), LETTER_BITS'($urandom),
			ADDR_W'($urandom), SCORE_W'($urandom));
	endtask

	task automatic put_finish();
		send_item(CMD_FINISH, CODE_W'($urandom), 1'($urandom), LETTER_BITS'($urandom),
			ADDR_W'($urandom), SCORE_W'($urandom));
	endtask

	task automatic put_map(input logic [CODE_W-1:0] code, input logic v,
		input logic [LETTER_BITS-1:0] idx);
		send_item(CMD_MAP, code, v, idx, ADDR_W'($urandom), SCORE_W'($urandom));
	endtask

	task automatic put_score(input logic [ADDR_W-1:0] addr, input logic [SCORE_W-1:0] val);
		send_item(CMD_SCORE, CODE_W'($urandom), 1'($urandom), LETTER_BITS'($urandom),
			addr, val);
	endtask

	// drain, let trailing text transactions finish, then write the length
	task automatic set_length(input logic [LEN_W-1:0] len);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int pick;
		logic v;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			put_text(($urandom_range(0, 4) != 0) ? CODE_W'($urandom_range(64, 95))
				: CODE_W'($urandom_range(0, 255)));
		end else if (pick < 78) begin
			put_finish();
		end else if (pick < 90) begin
			put_score(($urandom_range(0, 3) != 0) ? gram_address(8'($urandom))
				: ADDR_W'($urandom), SCORE_W'($urandom));
		end else if ($urandom_range(0, 9) < 7) begin
			v = ($urandom_range(0, 4) != 0);
			put_map(CODE_W'($urandom_range(64, 95)), v, v ? pick_letter() : LETTER_BITS'($urandom));
		end else begin
			v = 1'($urandom);
			put_map(CODE_W'($urandom), v, v ? pick_letter() : LETTER_BITS'($urandom));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_MAP;
		char_code <= '0;
		map_valid <= 1'b0;
		map_index <= '0;
		table_address <= '0;
		score_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// score table over every window the alphabet can form
		for (int k = 0; k < 256; k++) begin
			put_score(gram_address(8'(k)), (k == 0 || k == 85) ? '1 : SCORE_W'($urandom));
		end
		for (int c = 64; c < 96; c++) begin
			put_map(CODE_W'(c), 1'b1, pick_letter());
		end

		// directed: empty text, extremes of the map, short text, dropped characters
		put_finish();
		put_map(8'd0, 1'b1, 5'd31);
		put_map(8'd255, 1'b1, 5'd0);
		put_map(8'd128, 1'b0, 5'd31);
		put_text(8'd255);
		put_text(8'd128);
		put_text(8'd0);
		put_text(8'd0);
		put_finish();
		put_text(8'd0);
		put_text(8'd0);
		put_text(8'd0);
		put_text(8'd0);
		put_text(8'd255);
		put_finish();
		put_score(20'hFFFFF, 16'h0000);
		put_score(20'h00000, 16'hFFFF);
		set_length(3'd1);
		put_text(8'd255);
		put_text(8'd255);
		put_finish();
		set_length(3'd0);
		put_text(8'd0);
		put_finish();
		set_length(3'd7);
		put_text(8'd0);
		put_text(8'd255);
		put_finish();
		// length changed in the middle of a text
		set_length(3'd2);
		put_text(8'd0);
		put_text(8'd0);
		put_text(8'd0);
		set_length(3'd4);
		put_text(8'd255);
		put_text(8'd0);
		put_finish();

		for (int p = 0; p < PHASES; p++) begin
			set_length((p < 8) ? LENGTH_PLAN[p*LEN_W +: LEN_W] : LEN_W'($urandom));
			if (p >= PHASES - 2) begin
				calm = 1'b1;
			end
			if (p == 3) begin
				hold_req = 1'b1;
				for (int j = 0; j < 6; j++) begin
					put_text(CODE_W'($urandom_range(64, 95)));
					put_text(CODE_W'($urandom_range(64, 95)));
					put_finish();
				end
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_item();
			end
		end
		put_finish();

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ngram_fitness_scorer_top verification clean");
		end else begin
			$display("ngram_fitness_scorer_top verification failed");
		end
		$finish;
	end

endmodule
